### hw/rtl/fir_filter_reflect_edges_macros.svh
// Assertion macros for the mirrored-edge FIR filter.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef FIR_FILTER_REFLECT_EDGES_MACROS_SVH
`define FIR_FILTER_REFLECT_EDGES_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising clk edge outside reset.
`define FRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fir filter assertion failed");
// Condition that must never hold outside reset.
`define FRF_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fir filter forbidden condition seen");
`else
`define FRF_ASSERT(lbl, prop)
`define FRF_NEVER(lbl, cond)
`endif

`endif

### hw/rtl/frf_pkg.sv
// Shared types, constants and helper function for the mirrored-edge FIR filter.
// No dependencies.
`timescale 1ns / 1ps

package frf_pkg;

  localparam int SAMPLE_W  = 20;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = 14;
  localparam int OUT_W     = 27;
  localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
  localparam int NUM_COEF  = 7;
  localparam int TAPCNT_W  = 3;
  localparam int CFG_IDX_W = 3;
  // signed width for tap positions relative to the newest sample
  localparam int POS_W     = 8;

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_0    = 3'd1;

  localparam logic [TAPCNT_W-1:0]      TAPS_RESET = 3'd7;
  localparam logic signed [COEF_W-1:0] COEF_RESET = 18'sd2340;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                final_sample;
  } frf_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    final_result;
  } frf_out_t;

  typedef struct packed {
    logic load_op;
    logic load_prod;
  } frf_tap_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } frf_beat_t;

  // Distance back from the newest sample after mirroring about the first
  // and last sample of the sequence; k is the index of the newest sample.
  function automatic logic [POS_W-1:0] mirror_back(input logic signed [POS_W-1:0] r,
                                                   input logic signed [POS_W-1:0] k);
    logic signed [POS_W-1:0] b;
    if (r < 0) begin
      b = -r;
      if (b > k) b = k;
    end else if (r > k) begin
      b = (k <<< 1) - r;
      if (b < 0) b = '0;
    end else begin
      b = r;
    end
    return b;
  endfunction

endpackage

### hw/rtl/frf_win_cell.sv
// One stage of the sample window shift line.
// Depends on frf_pkg.
`timescale 1ns / 1ps

module frf_win_cell (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [frf_pkg::SAMPLE_W-1:0] d_in,
  output logic [frf_pkg::SAMPLE_W-1:0] q_nxt,
  output logic [frf_pkg::SAMPLE_W-1:0] q
);
  import frf_pkg::*;

  logic [SAMPLE_W-1:0] q_r;

  assign q_nxt = shift ? d_in : q_r;
  assign q     = q_r;

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

### hw/rtl/frf_tap_cell.sv
// One filter tap: operand register and registered weight product.
// Depends on frf_pkg.
`timescale 1ns / 1ps

module frf_tap_cell (
  input  logic                              clk,
  input  frf_pkg::frf_tap_ctl_t             ctl,
  input  logic [frf_pkg::SAMPLE_W-1:0]      op_in,
  input  logic                              tap_on,
  input  logic signed [frf_pkg::COEF_W-1:0] coef,
  output logic signed [frf_pkg::PROD_W-1:0] prod
);
  import frf_pkg::*;

  logic [SAMPLE_W-1:0]      op_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  // unused taps carry a zero operand
  assign prod_nxt = coef * $signed({1'b0, op_r});
  assign prod     = prod_r;

  always_ff @(posedge clk) begin
    if (ctl.load_op) begin
      op_r <= tap_on ? op_in : '0;
    end
    if (ctl.load_prod) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### hw/rtl/frf_accum.sv
// Registered adder tree over the tap products, scaling, saturation and
// output register. Depends on frf_pkg.
`timescale 1ns / 1ps

module frf_accum #(
  parameter int NUM_TAPS = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  frf_pkg::frf_beat_t                beat_in,
  input  logic signed [frf_pkg::PROD_W-1:0] prod [NUM_TAPS],
  output logic                              ready,
  input  logic                              out_stall,
  output logic                              out_valid,
  output frf_pkg::frf_out_t                 out_data
);
  import frf_pkg::*;

  localparam int LEVELS = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int LEAVES = 1 << LEVELS;
  localparam int SUM_W  = PROD_W + LEVELS;

  logic signed [SUM_W-1:0] leaf [LEAVES];
  logic signed [SUM_W-1:0] node_r [1:LEAVES-1];
  logic [LEVELS:1]         tv_r;
  logic [LEVELS:1]         tf_r;
  logic                    ov_r;
  frf_out_t                out_data_r;
  frf_out_t                out_data_nxt;
  logic [LEVELS+1:1]       en_t;
  logic signed [SUM_W-1:0] biased;
  logic signed [SUM_W-1:0] quot;

  genvar gi;
  for (gi = 0; gi < LEAVES; gi++) begin : g_leaf
    if (gi < NUM_TAPS) begin : g_prod
      assign leaf[gi] = SUM_W'(prod[gi]);
    end else begin : g_pad
      assign leaf[gi] = '0;
    end
  end

  // heap order: node 1 is the root, each level one pipeline stage
  for (gi = 1; gi < LEAVES; gi++) begin : g_node
    localparam int STG = LEVELS + 1 - $clog2(gi + 1);
    logic signed [SUM_W-1:0] sum_a;
    logic signed [SUM_W-1:0] sum_b;
    if (2 * gi >= LEAVES) begin : g_from_leaf
      assign sum_a = leaf[2 * gi - LEAVES];
      assign sum_b = leaf[2 * gi + 1 - LEAVES];
    end else begin : g_from_node
      assign sum_a = node_r[2 * gi];
      assign sum_b = node_r[2 * gi + 1];
    end
    always_ff @(posedge clk) begin
      if (en_t[STG]) begin
        node_r[gi] <= sum_a + sum_b;
      end
    end
  end

  // a stage loads when empty or when its contents move on
  always_comb begin
    en_t[LEVELS+1] = !ov_r || !out_stall;
    for (int s = LEVELS; s >= 1; s--) begin
      en_t[s] = !tv_r[s] || en_t[s+1];
    end
  end

  assign ready = en_t[1];

  // divide by 2^COEF_FRAC truncating toward zero, then clamp
  always_comb begin
    biased = node_r[1] + (node_r[1][SUM_W-1] ? SUM_W'((1 << COEF_FRAC) - 1) : SUM_W'(0));
    quot   = biased >>> COEF_FRAC;
    if (quot > SUM_W'(OUT_MAX)) begin
      out_data_nxt.filtered = OUT_W'(OUT_MAX);
    end else if (quot < SUM_W'(OUT_MIN)) begin
      out_data_nxt.filtered = OUT_W'(OUT_MIN);
    end else begin
      out_data_nxt.filtered = quot[OUT_W-1:0];
    end
    out_data_nxt.final_result = tf_r[LEVELS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (en_t[1]) begin
        tv_r[1] <= beat_in.valid;
      end
      for (int s = 2; s <= LEVELS; s++) begin
        if (en_t[s]) begin
          tv_r[s] <= tv_r[s-1];
        end
      end
      if (en_t[LEVELS+1]) begin
        ov_r <= tv_r[LEVELS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_t[1]) begin
      tf_r[1] <= beat_in.last;
    end
    for (int s = 2; s <= LEVELS; s++) begin
      if (en_t[s]) begin
        tf_r[s] <= tf_r[s-1];
      end
    end
    if (en_t[LEVELS+1]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/fir_filter_reflect_edges.sv
// FIR filter of 1 to 7 taps over a sample stream with edges mirrored about the
// first and last sample of each sequence. Depends on frf_pkg, frf_win_cell,
// frf_tap_cell, frf_accum and the assertion macro header.
`timescale 1ns / 1ps

`include "fir_filter_reflect_edges_macros.svh"

// Takes one sample per cycle while in_stall is low and gives one result per
// cycle while out_stall is low. A sample that closes a sequence releases its
// pending outputs one per cycle when the pipeline is not stalled, holding
// in_stall high while they issue, up to wing = (taps-1)/2 of them (three at
// seven taps); the issue stage steers window samples to the tap cells one
// output at a time. A sample enters a shift line of window cells; each output
// then passes an operand stage, a product stage, a registered adder tree of
// clog2(NUM_CELLS) levels and the output register. Results queue in the
// pipeline while out_stall is high, and samples are still taken until it
// fills. Write tap_count and the weights only while the block is idle;
// cfg_ready is always high.
module fir_filter_reflect_edges #(
  parameter int MAX_TAPS = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  frf_pkg::frf_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output frf_pkg::frf_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frf_pkg::COEF_W-1:0]     cfg_data
);
  import frf_pkg::*;

  localparam int NUM_CELLS = (MAX_TAPS < NUM_COEF) ? MAX_TAPS : NUM_COEF;
  localparam int CNT_W     = $clog2(MAX_TAPS + 1);
  localparam int IDX_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  // configuration
  logic [TAPCNT_W-1:0]      tap_count_r;
  logic signed [COEF_W-1:0] coef_r [NUM_COEF];

  // sequence and flush control
  logic [CNT_W-1:0] cnt_r;
  logic             flush_r;
  logic [1:0]       flush_d_r;
  logic [CNT_W-1:0] flush_k_r;

  // pipeline valid bits ahead of the adder tree
  logic v1_r, fin1_r, v2_r, fin2_r;
  logic en1, en2, acc_ready;

  logic                in_acc;
  logic                emits;
  logic                iss_go;
  logic                iss_last;
  logic [TAPCNT_W-1:0] taps_eff;
  logic [1:0]          wing;
  logic [1:0]          first_d;
  logic [1:0]          d_sel;
  logic [CNT_W-1:0]    k_sel;

  logic [SAMPLE_W-1:0]      win_q   [MAX_TAPS];
  logic [SAMPLE_W-1:0]      win_nxt [MAX_TAPS];
  logic signed [POS_W-1:0]  pos     [NUM_CELLS];
  logic [POS_W-1:0]         back    [NUM_CELLS];
  logic [SAMPLE_W-1:0]      tap_op  [NUM_CELLS];
  logic [NUM_CELLS-1:0]     tap_on;
  logic signed [PROD_W-1:0] prod    [NUM_CELLS];
  frf_tap_ctl_t             tap_ctl;
  frf_beat_t                acc_beat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPS_RESET;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= COEF_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TAP_COUNT: tap_count_r <= cfg_data[TAPCNT_W-1:0];
        default:       coef_r[CFG_IDX_W'(cfg_index - CFG_COEF_0)] <= cfg_data;
      endcase
    end
  end

  // issue control
  always_comb begin
    taps_eff = (int'(tap_count_r) > MAX_TAPS) ? TAPCNT_W'(MAX_TAPS) : tap_count_r;
    wing     = (taps_eff == '0) ? 2'd0 : 2'((taps_eff - 3'd1) >> 1);
    first_d  = (cnt_r < wing) ? 2'(cnt_r) : wing;
    emits    = in_data.final_sample || (cnt_r >= wing);

    en2      = !v2_r || acc_ready;
    en1      = !v1_r || en2;
    in_stall = flush_r || !en1;
    in_acc   = in_valid && !in_stall;

    if (flush_r) begin
      iss_go   = en1;
      iss_last = (flush_d_r == 2'd0);
      d_sel    = flush_d_r;
      k_sel    = flush_k_r;
    end else begin
      iss_go   = in_acc && emits;
      iss_last = in_data.final_sample && (first_d == 2'd0);
      d_sel    = in_data.final_sample ? first_d : wing;
      k_sel    = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      flush_r   <= 1'b0;
      flush_d_r <= 2'd0;
      flush_k_r <= '0;
    end else if (in_acc) begin
      if (in_data.final_sample) begin
        cnt_r <= '0;
        if (first_d != 2'd0) begin
          flush_r   <= 1'b1;
          flush_d_r <= first_d - 2'd1;
          flush_k_r <= cnt_r;
        end
      end else if (cnt_r < CNT_W'(MAX_TAPS)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end else if (flush_r && en1) begin
      if (flush_d_r == 2'd0) begin
        flush_r <= 1'b0;
      end else begin
        flush_d_r <= flush_d_r - 2'd1;
      end
    end
  end

  // sample window: newest in cell 0
  genvar gi;
  for (gi = 0; gi < MAX_TAPS; gi++) begin : g_win
    if (gi == 0) begin : g_head
      frf_win_cell u_cell (
        .clk   (clk),
        .shift (in_acc),
        .d_in  (in_data.sample),
        .q_nxt (win_nxt[gi]),
        .q     (win_q[gi])
      );
    end else begin : g_body
      frf_win_cell u_cell (
        .clk   (clk),
        .shift (in_acc),
        .d_in  (win_q[gi-1]),
        .q_nxt (win_nxt[gi]),
        .q     (win_q[gi])
      );
    end
  end

  // steer mirrored window samples to the taps
  always_comb begin
    for (int j = 0; j < NUM_CELLS; j++) begin
      pos[j]  = POS_W'(d_sel) + POS_W'(wing) - POS_W'(j);
      back[j] = mirror_back(pos[j], POS_W'(k_sel));
      if (back[j] > POS_W'(MAX_TAPS - 1)) begin
        back[j] = POS_W'(MAX_TAPS - 1);
      end
      tap_op[j] = win_nxt[back[j][IDX_W-1:0]];
      tap_on[j] = (j < int'(taps_eff));
    end
  end

  assign tap_ctl = '{load_op: en1, load_prod: en2};

  for (gi = 0; gi < NUM_CELLS; gi++) begin : g_tap
    frf_tap_cell u_tap (
      .clk    (clk),
      .ctl    (tap_ctl),
      .op_in  (tap_op[gi]),
      .tap_on (tap_on[gi]),
      .coef   (coef_r[gi]),
      .prod   (prod[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= iss_go;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) fin1_r <= iss_last;
    if (en2) fin2_r <= fin1_r;
  end

  assign acc_beat = '{valid: v2_r, last: fin2_r};

  frf_accum #(
    .NUM_TAPS (NUM_CELLS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_in   (acc_beat),
    .prod      (prod),
    .ready     (acc_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `FRF_ASSERT(a_cnt_clear_in_flush, flush_r |-> (cnt_r == '0))
  `FRF_ASSERT(a_flush_start, (in_acc && in_data.final_sample && first_d != 2'd0) |=> flush_r)
  `FRF_ASSERT(a_flush_end, (flush_r && en1 && flush_d_r == 2'd0) |=> !flush_r)
  `FRF_NEVER(a_no_issue_past_last, flush_r && iss_go && iss_last && flush_d_r != 2'd0)

endmodule
